// ----- hdl/staggered_divergence_max_core_defines.svh -----
// Assertion macros shared by the staggered divergence core.
// No dependencies; included by files that carry concurrent assertions.
`ifndef STAGGERED_DIVERGENCE_MAX_CORE_DEFINES_SVH
`define STAGGERED_DIVERGENCE_MAX_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define SDM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define SDM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/sdm_pkg.sv -----
// Shared widths, constants and beat types of the staggered divergence core.
// No dependencies.
`default_nettype none

package sdm_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int VEL_W         = 32;
    localparam int SPC_W         = 31;
    localparam int PROD_W        = 62;
    localparam int QUOT_W        = 60;
    localparam int MUL_STEPS     = VEL_W;

    localparam logic [SPC_W-1:0] Z_SPACING_RST = SPC_W'(65536);

    typedef struct packed {
        logic signed [VEL_W-1:0] ux_low;
        logic signed [VEL_W-1:0] ux_high;
        logic signed [VEL_W-1:0] uy_low;
        logic signed [VEL_W-1:0] uy_high;
        logic signed [VEL_W-1:0] uz_low;
        logic signed [VEL_W-1:0] uz_high;
        logic        [SPC_W-1:0] hx_low;
        logic        [SPC_W-1:0] hx_high;
        logic        [SPC_W-1:0] hy_cell;
        logic        [SPC_W-1:0] jd_low;
        logic        [SPC_W-1:0] jd_mid;
        logic        [SPC_W-1:0] jd_high;
    } t_cell;

    typedef struct packed {
        logic signed [VEL_W-1:0] divergence;
        logic        [SPC_W-1:0] max_abs_div;
    } t_result;

endpackage

`default_nettype wire

// ----- hdl/sdm_if.sv -----
// Valid/ready channel interfaces for cell beats and result beats.
// Depends on sdm_pkg for the payload types.
`default_nettype none

interface sdm_in_if import sdm_pkg::*; ();
    logic  valid;
    logic  ready;
    t_cell data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sdm_out_if import sdm_pkg::*; ();
    logic    valid;
    logic    ready;
    t_result data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hdl/sdm_mul.sv -----
// Bit-serial shift-add multiplier: one multiplier bit per cycle, 32-bit adder.
// Depends on sdm_pkg.
`default_nettype none

module sdm_mul
    import sdm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [SPC_W-1:0]  i_a,
    input  logic [VEL_W-1:0]  i_b,
    output logic              o_done,
    output logic [PROD_W-1:0] o_prod
);

    localparam int CNT_W = $clog2(MUL_STEPS);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [SPC_W-1:0]   r_a;
    logic [SPC_W-1:0]   r_hi;
    logic [VEL_W-1:0]   r_lo;
    logic [VEL_W-1:0]   step_sum;
    logic [SPC_W+VEL_W-1:0] full_prod;

    assign step_sum  = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_a} : {VEL_W{1'b0}});
    assign full_prod = {r_hi, r_lo};
    assign o_prod    = full_prod[PROD_W-1:0];
    assign o_done    = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(MUL_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a  <= i_a;
            r_hi <= '0;
            r_lo <= i_b;
        end else if (r_busy) begin
            r_hi <= step_sum[VEL_W-1:1];
            r_lo <= {step_sum[0], r_lo[VEL_W-1:1]};
        end
    end

endmodule

`default_nettype wire

// ----- hdl/sdm_div.sv -----
// Restoring serial divider: one quotient bit per cycle, saturating at 2^60-1.
// Depends on sdm_pkg.
`default_nettype none

module sdm_div
    import sdm_pkg::*;
#(
    parameter int NUM_W = PROD_W + FRAC_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [NUM_W-1:0]          i_num,
    input  logic [SPC_W-1:0]          i_den,
    input  logic [$clog2(NUM_W)-1:0]  i_steps,
    output logic                      o_done,
    output logic [QUOT_W-1:0]         o_quot
);

    localparam int STEP_W = $clog2(NUM_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [NUM_W-1:0]  r_num;
    logic [SPC_W-1:0]  r_den;
    logic [SPC_W-1:0]  r_rem;
    logic [QUOT_W:0]   r_q;
    logic              r_ovf;
    logic              r_zero;
    logic [SPC_W:0]    trial;
    logic [SPC_W:0]    diff;
    logic              take;

    assign trial  = {r_rem, r_num[NUM_W-1]};
    assign diff   = trial - {1'b0, r_den};
    assign take   = (trial >= {1'b0, r_den});
    assign o_done = r_done;
    assign o_quot = (r_zero || r_ovf || r_q[QUOT_W]) ? {QUOT_W{1'b1}} : r_q[QUOT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - STEP_W'(1);
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= i_num;
            r_den  <= i_den;
            r_rem  <= '0;
            r_q    <= '0;
            r_ovf  <= 1'b0;
            r_zero <= (i_den == '0);
        end else if (r_busy) begin
            r_num <= {r_num[NUM_W-2:0], 1'b0};
            r_rem <= take ? diff[SPC_W-1:0] : trial[SPC_W-1:0];
            r_q   <= {r_q[QUOT_W-1:0], take};
            r_ovf <= r_ovf | r_q[QUOT_W];
        end
    end

endmodule

`default_nettype wire

// ----- hdl/staggered_divergence_max_core.sv -----
// A new cell is accepted only in the idle state, once the previous result is emitted; the
// serial divider retires one quotient bit per cycle over five divisions, the multiplier
// one bit.
// Reset (synchronous, active low) clears the running maximum, the output valid
// and the sequencer, and sets z_spacing to 1.0.
`default_nettype none
`include "staggered_divergence_max_core_defines.svh"

module staggered_divergence_max_core
    import sdm_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [SPC_W-1:0] i_cfg_wr_data,
    sdm_in_if.sink           i_cell,
    sdm_out_if.source        o_res
);

    localparam int NUM_W  = PROD_W + FRAC_BITS;
    localparam int STEP_W = $clog2(NUM_W);
    localparam int XMAG_W = PROD_W - 1;
    localparam int YMAG_W = VEL_W + 1;
    localparam int XPAD_W = NUM_W - XMAG_W - FRAC_BITS;
    localparam int YPAD_W = NUM_W - YMAG_W - FRAC_BITS;
    localparam int ACC_W  = QUOT_W + 3;

    localparam logic [STEP_W-1:0] STEPS_FLUX = STEP_W'(PROD_W);
    localparam logic [STEP_W-1:0] STEPS_X    = STEP_W'(XMAG_W + FRAC_BITS);
    localparam logic [STEP_W-1:0] STEPS_YZ   = STEP_W'(YMAG_W + FRAC_BITS);

    localparam logic [VEL_W-1:0] SAT_POS = {1'b0, {(VEL_W-1){1'b1}}};
    localparam logic [VEL_W-1:0] SAT_NEG = {1'b1, {(VEL_W-1){1'b0}}};

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_LOAD = 5'b00010,
        S_MUL  = 5'b00100,
        S_DIV  = 5'b01000,
        S_EMIT = 5'b10000
    } t_state;

    typedef enum logic [2:0] {
        OP_FLUX_HI,
        OP_FLUX_LO,
        OP_DIV_X,
        OP_DIV_Y,
        OP_DIV_Z
    } t_op;

    function automatic logic [VEL_W-1:0] abs_vel(input logic [VEL_W-1:0] v);
        return v[VEL_W-1] ? (~v + VEL_W'(1)) : v;
    endfunction

    function automatic logic [SPC_W-1:0] sat_mag(input logic [VEL_W-1:0] v);
        logic [VEL_W-1:0] m;
        m = abs_vel(v);
        return m[VEL_W-1] ? {SPC_W{1'b1}} : m[SPC_W-1:0];
    endfunction

    t_state              r_state, n_state;
    t_op                 r_op, n_op;
    logic signed [ACC_W-1:0] r_acc, n_acc;
    logic                r_neg, n_neg;
    t_cell               r_cell;
    logic [SPC_W-1:0]    r_zsp;
    logic [SPC_W-1:0]    r_max;
    t_result             r_out;
    logic                r_out_valid;

    logic                mul_start, mul_done;
    logic [SPC_W-1:0]    mul_a;
    logic [VEL_W-1:0]    mul_b;
    logic [PROD_W-1:0]   mul_prod;
    logic                div_start, div_done;
    logic [NUM_W-1:0]    div_num;
    logic [SPC_W-1:0]    div_den;
    logic [STEP_W-1:0]   div_steps;
    logic [QUOT_W-1:0]   div_quot;
    logic                ld_neg;
    logic                emit;

    logic [ACC_W-1:0]    acc_mag;
    logic signed [YMAG_W-1:0] ydiff, zdiff;
    logic [YMAG_W-1:0]   ymag, zmag;
    logic [ACC_W-1:0]    q_ext, addend;
    logic                sum_hi, sum_lo;
    logic [VEL_W-1:0]    sat_div;
    logic [SPC_W-1:0]    div_mag, n_max;
    logic [SPC_W-1:0]    out_mag;

    sdm_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    sdm_div #(
        .NUM_W (NUM_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .i_steps (div_steps),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign i_cell.ready = (r_state == S_IDLE);
    assign o_res.valid  = r_out_valid;
    assign o_res.data   = r_out;

    assign acc_mag = r_acc[ACC_W-1] ? (~r_acc + ACC_W'(1)) : r_acc;
    assign ydiff   = {r_cell.uy_high[VEL_W-1], r_cell.uy_high}
                   - {r_cell.uy_low[VEL_W-1], r_cell.uy_low};
    assign zdiff   = {r_cell.uz_high[VEL_W-1], r_cell.uz_high}
                   - {r_cell.uz_low[VEL_W-1], r_cell.uz_low};
    assign ymag    = ydiff[YMAG_W-1] ? (~ydiff + YMAG_W'(1)) : ydiff;
    assign zmag    = zdiff[YMAG_W-1] ? (~zdiff + YMAG_W'(1)) : zdiff;

    assign q_ext  = {{(ACC_W-QUOT_W){1'b0}}, div_quot};
    assign addend = (r_neg ^ (r_op == OP_FLUX_LO)) ? (~q_ext + ACC_W'(1)) : q_ext;

    assign sum_hi  = !r_acc[ACC_W-1] && (|r_acc[ACC_W-2:VEL_W-1]);
    assign sum_lo  = r_acc[ACC_W-1] && !(&r_acc[ACC_W-2:VEL_W-1]);
    assign sat_div = sum_hi ? SAT_POS : (sum_lo ? SAT_NEG : r_acc[VEL_W-1:0]);
    assign div_mag = sat_mag(sat_div);
    assign n_max   = (div_mag > r_max) ? div_mag : r_max;
    assign out_mag = sat_mag(r_out.divergence);

    always_comb begin
        mul_a     = r_cell.jd_high;
        mul_b     = abs_vel(r_cell.ux_high);
        ld_neg    = r_cell.ux_high[VEL_W-1];
        div_den   = r_cell.hx_high;
        div_num   = {mul_prod, {FRAC_BITS{1'b0}}};
        div_steps = STEPS_FLUX;
        case (r_op)
            OP_FLUX_LO: begin
                mul_a   = r_cell.jd_low;
                mul_b   = abs_vel(r_cell.ux_low);
                ld_neg  = r_cell.ux_low[VEL_W-1];
                div_den = r_cell.hx_low;
            end
            OP_DIV_X: begin
                ld_neg    = r_acc[ACC_W-1];
                div_den   = r_cell.jd_mid;
                div_num   = {acc_mag[XMAG_W-1:0], {FRAC_BITS{1'b0}}, {XPAD_W{1'b0}}};
                div_steps = STEPS_X;
            end
            OP_DIV_Y: begin
                ld_neg    = ydiff[YMAG_W-1];
                div_den   = r_cell.hy_cell;
                div_num   = {ymag, {FRAC_BITS{1'b0}}, {YPAD_W{1'b0}}};
                div_steps = STEPS_YZ;
            end
            OP_DIV_Z: begin
                ld_neg    = zdiff[YMAG_W-1];
                div_den   = r_zsp;
                div_num   = {zmag, {FRAC_BITS{1'b0}}, {YPAD_W{1'b0}}};
                div_steps = STEPS_YZ;
            end
            default: begin
                mul_a = r_cell.jd_high;
            end
        endcase
    end

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_acc     = r_acc;
        n_neg     = r_neg;
        mul_start = 1'b0;
        div_start = 1'b0;
        emit      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_cell.valid) begin
                    n_state = S_LOAD;
                    n_op    = OP_FLUX_HI;
                    n_acc   = '0;
                end
            end
            S_LOAD: begin
                n_neg = ld_neg;
                if (r_op == OP_FLUX_HI || r_op == OP_FLUX_LO) begin
                    mul_start = 1'b1;
                    n_state   = S_MUL;
                end else begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                    if (r_op == OP_DIV_X) begin
                        n_acc = '0;
                    end
                end
            end
            S_MUL: begin
                if (mul_done) begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_acc = r_acc + addend;
                    if (r_op == OP_DIV_Z) begin
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_LOAD;
                        unique case (r_op)
                            OP_FLUX_HI: n_op = OP_FLUX_LO;
                            OP_FLUX_LO: n_op = OP_DIV_X;
                            OP_DIV_X:   n_op = OP_DIV_Y;
                            default:    n_op = OP_DIV_Z;
                        endcase
                    end
                end
            end
            S_EMIT: begin
                if (!r_out_valid || o_res.ready) begin
                    emit    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_zsp       <= Z_SPACING_RST;
            r_max       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_zsp <= i_cfg_wr_data;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
                r_max       <= n_max;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op  <= n_op;
        r_acc <= n_acc;
        r_neg <= n_neg;
        if (i_cell.valid && i_cell.ready) begin
            r_cell <= i_cell.data;
        end
        if (emit) begin
            r_out.divergence  <= sat_div;
            r_out.max_abs_div <= n_max;
        end
    end

    `SDM_ASSERT_IMP(a_mul_done_in_mul, i_clk, i_rst_n, mul_done, r_state == S_MUL,
        "multiplier finished outside the multiply state")
    `SDM_ASSERT_IMP(a_div_done_in_div, i_clk, i_rst_n, div_done, r_state == S_DIV,
        "divider finished outside the divide state")
    `SDM_ASSERT_NXT(a_max_monotone, i_clk, i_rst_n, 1'b1, r_max >= $past(r_max),
        "running maximum decreased")
    `SDM_ASSERT_IMP(a_max_covers_beat, i_clk, i_rst_n, r_out_valid,
        r_out.max_abs_div >= out_mag, "result beat exceeds its running maximum")

endmodule

`default_nettype wire

// ----- test/tb.sv -----
// Self-checking testbench for staggered_divergence_max_core: cell beats in, divergence beats out.
// Depends on sdm_pkg, the sdm_in_if/sdm_out_if channel interfaces and the core RTL.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sdm_pkg::*;

    localparam int             QUIET_LIMIT = 4000;
    localparam int             PHASE_CELLS = 305;
    localparam logic [63:0]    QUOT_MAX    = (64'd1 << QUOT_W) - 64'd1;
    localparam longint         DIV_HI      = 64'sd2147483647;
    localparam longint         DIV_LO      = -64'sd2147483648;
    localparam logic [VEL_W-1:0] V_ONE     = 32'h0001_0000;
    localparam logic [VEL_W-1:0] V_MAX     = 32'h7fff_ffff;
    localparam logic [VEL_W-1:0] V_MIN     = 32'h8000_0000;
    localparam logic [SPC_W-1:0] S_ONE     = 31'h0001_0000;
    localparam logic [SPC_W-1:0] S_MAX     = 31'h7fff_ffff;

    typedef struct {
        t_cell   stim;
        bit      typed;
        t_result want;
    } t_row;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_wr_en;
    logic [SPC_W-1:0] i_cfg_wr_data;

    sdm_in_if  cell_if ();
    sdm_out_if res_if ();

    staggered_divergence_max_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cell        (cell_if),
        .o_res         (res_if)
    );

    t_result          div_queue[$];
    t_row             cell_table[$];
    logic [SPC_W-1:0] z_spacing_q;
    logic [SPC_W-1:0] peak_abs;
    int               fails = 0;
    int               quiet = 0;
    bit               tx_steady = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic flag(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        fails++;
    endtask

    function automatic logic [63:0] mag64(input longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    // floor(m * 2^sh / den), clamped, with the sign applied afterwards
    function automatic longint ratio(input logic [63:0] m, input bit neg, input int sh,
                                     input logic [SPC_W-1:0] den);
        logic [127:0] wide;
        logic [63:0]  q;
        if (den == '0) begin
            q = QUOT_MAX;
        end else begin
            wide = ({64'd0, m} << sh) / {97'd0, den};
            q = (wide > {64'd0, QUOT_MAX}) ? QUOT_MAX : wide[63:0];
        end
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic t_result predict_divergence(input t_cell c);
        longint      fx;
        longint      dy;
        longint      dz;
        longint      total;
        logic [63:0] m;
        t_result     r;
        fx = ratio(64'(c.jd_high) * mag64(longint'(signed'(c.ux_high))), c.ux_high[VEL_W-1],
                   0, c.hx_high)
           - ratio(64'(c.jd_low) * mag64(longint'(signed'(c.ux_low))), c.ux_low[VEL_W-1],
                   0, c.hx_low);
        dy = longint'(signed'(c.uy_high)) - longint'(signed'(c.uy_low));
        dz = longint'(signed'(c.uz_high)) - longint'(signed'(c.uz_low));
        total = ratio(mag64(fx), fx < 0, FRAC_BITS_DEF, c.jd_mid)
              + ratio(mag64(dy), dy < 0, FRAC_BITS_DEF, c.hy_cell)
              + ratio(mag64(dz), dz < 0, FRAC_BITS_DEF, z_spacing_q);
        if (total > DIV_HI) total = DIV_HI;
        if (total < DIV_LO) total = DIV_LO;
        m = mag64(total);
        if (m > 64'h7fff_ffff) m = 64'h7fff_ffff;
        if (m[SPC_W-1:0] > peak_abs) peak_abs = m[SPC_W-1:0];
        r.divergence  = total[VEL_W-1:0];
        r.max_abs_div = peak_abs;
        return r;
    endfunction

    function automatic t_cell mk(
        input logic [VEL_W-1:0] ux_l, input logic [VEL_W-1:0] ux_h,
        input logic [VEL_W-1:0] uy_l, input logic [VEL_W-1:0] uy_h,
        input logic [VEL_W-1:0] uz_l, input logic [VEL_W-1:0] uz_h,
        input logic [SPC_W-1:0] hx_l, input logic [SPC_W-1:0] hx_h,
        input logic [SPC_W-1:0] hy,   input logic [SPC_W-1:0] jd_l,
        input logic [SPC_W-1:0] jd_m, input logic [SPC_W-1:0] jd_h);
        t_cell c;
        c.ux_low  = ux_l;  c.ux_high = ux_h;
        c.uy_low  = uy_l;  c.uy_high = uy_h;
        c.uz_low  = uz_l;  c.uz_high = uz_h;
        c.hx_low  = hx_l;  c.hx_high = hx_h;
        c.hy_cell = hy;
        c.jd_low  = jd_l;  c.jd_mid  = jd_m;  c.jd_high = jd_h;
        return c;
    endfunction

    task automatic add_row(input t_cell c, input bit typed = 1'b0, input t_result want = '0);
        t_row row;
        row.stim  = c;
        row.typed = typed;
        row.want  = want;
        cell_table.push_back(row);
    endtask

    function automatic logic [SPC_W-1:0] rand_spacing(input bit rough);
        logic [SPC_W-1:0] s;
        s = SPC_W'($urandom());
        if (rough && $urandom_range(0, 7) == 0) s = SPC_W'($urandom_range(1, 1023));
        if (s == '0) s = SPC_W'(1);
        return s;
    endfunction

    function automatic t_cell rand_cell(input bit rough);
        t_cell c;
        c.ux_low  = $urandom();
        c.ux_high = $urandom();
        c.uy_low  = $urandom();
        c.uy_high = ($urandom_range(0, 4) == 0) ? c.uy_low : VEL_W'($urandom());
        c.uz_low  = $urandom();
        c.uz_high = ($urandom_range(0, 2) == 0) ? c.uz_low : VEL_W'($urandom());
        c.hx_low  = rand_spacing(rough);
        c.hx_high = rand_spacing(rough);
        c.hy_cell = rand_spacing(rough);
        c.jd_low  = rand_spacing(1'b0);
        c.jd_mid  = rand_spacing(rough);
        c.jd_high = rand_spacing(1'b0);
        return c;
    endfunction

    task automatic send_cell(input t_cell c, input bit typed, input t_result want);
        int      gap;
        t_result guess;
        gap = tx_steady ? 0 : $urandom_range(0, 11);
        if ($urandom_range(0, 39) == 0) tx_steady = !tx_steady;
        if (gap > 0) begin
            cell_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cell_if.valid <= 1'b1;
        cell_if.data  <= c;
        do @(posedge i_clk); while (!cell_if.ready);
        guess = predict_divergence(c);
        div_queue.push_back(typed ? want : guess);
    endtask

    // drop valid and hold until every divergence beat is back
    task automatic settle();
        cell_if.valid <= 1'b0;
        while (div_queue.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_z_spacing(input logic [SPC_W-1:0] v);
        settle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        z_spacing_q = v;
    endtask

    initial begin : result_sink
        int      stall;
        bit      steady;
        t_result want;
        stall  = 0;
        steady = 1'b0;
        res_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (res_if.valid && res_if.ready) begin
                if (div_queue.size() == 0) begin
                    flag("result beat with nothing expected");
                end else begin
                    want = div_queue.pop_front();
                    if (res_if.data.divergence !== want.divergence)
                        flag($sformatf("divergence got %h want %h",
                                       res_if.data.divergence, want.divergence));
                    if (res_if.data.max_abs_div !== want.max_abs_div)
                        flag($sformatf("max_abs_div got %h want %h",
                                       res_if.data.max_abs_div, want.max_abs_div));
                end
                if ($urandom_range(0, 39) == 0) steady = !steady;
                stall = steady ? 0 : $urandom_range(0, 11);
            end
            res_if.ready <= (stall == 0);
            if (stall > 0) stall--;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (cell_if.valid && cell_if.ready) || (res_if.valid && res_if.ready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet >= QUIET_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int               n_early;
        logic [SPC_W-1:0] z_set [4];
        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= '0;
        cell_if.valid <= 1'b0;
        cell_if.data  <= '0;
        z_spacing_q = Z_SPACING_RST;
        peak_abs    = '0;

        add_row(mk(0, 0, 0, 0, 0, 0, S_ONE, S_ONE, S_ONE, S_ONE, S_ONE, S_ONE),
                1'b1, t_result'{32'h0, 31'h0});
        add_row(mk(V_ONE, V_ONE, V_ONE, V_ONE, V_ONE, V_ONE,
                   S_ONE, S_ONE, S_ONE, S_ONE, S_ONE, S_ONE),
                1'b1, t_result'{32'h0, 31'h0});
        add_row(mk(0, 2 * V_ONE, 0, 0, 0, 0, S_ONE, S_ONE, S_ONE, S_ONE, S_ONE, S_ONE),
                1'b1, t_result'{32'h0002_0000, 31'h0002_0000});
        add_row(mk(0, 0, V_MIN, V_MAX, 0, 0, S_ONE, S_ONE, S_MAX, S_ONE, S_ONE, S_ONE));
        add_row(mk(0, 0, V_MAX, V_MIN, 0, 0, S_ONE, S_ONE, S_MAX, S_ONE, S_ONE, S_ONE));
        add_row(mk(0, 0, 0, 0, V_MIN, V_MIN, S_ONE, S_ONE, S_ONE, S_ONE, S_ONE, S_ONE));
        add_row(mk(V_MIN, V_MAX, 0, 0, 0, 0, S_MAX, S_MAX, S_ONE, S_MAX, S_MAX, S_MAX));
        add_row(mk(V_MAX, V_MIN, 0, 0, V_MAX, V_MAX, S_MAX, S_MAX, S_ONE, S_MAX, S_MAX, S_MAX));
        add_row(mk(V_MIN, V_MAX, 0, 0, 0, 0, 1, 1, S_ONE, 0, S_ONE, 0));
        add_row(mk(0, 1, 0, 0, 0, 0, S_ONE, 1, S_ONE, S_ONE, 1, 1));
        add_row(mk(3 * V_ONE, 0, 0, 0, 0, 0, S_ONE, S_ONE, S_ONE, S_ONE, S_ONE, S_ONE));
        add_row(mk(0, 0, 0, 1, 0, 0, S_ONE, S_ONE, 3, S_ONE, S_ONE, S_ONE));
        add_row(mk(0, 0, 1, 0, 0, 0, S_ONE, S_ONE, 3, S_ONE, S_ONE, S_ONE));
        add_row(mk(V_ONE, V_MIN, 0, 0, 0, 0, 1, S_MAX, S_ONE, 1, S_MAX, 1));
        n_early = cell_table.size();
        // saturating rows run last, once the running maximum has been exercised
        add_row(mk(0, 0, V_MIN, V_MAX, 5, 5, S_ONE, S_ONE, 1, S_ONE, S_ONE, S_ONE),
                1'b1, t_result'{32'h7fff_ffff, S_MAX});
        add_row(mk(0, 0, V_MAX, V_MIN, 7, 7, S_ONE, S_ONE, 1, S_ONE, S_ONE, S_ONE),
                1'b1, t_result'{32'h8000_0000, S_MAX});
        add_row(mk(0, 0, 32'h0000_8000, 0, 0, 0, S_ONE, S_ONE, 1, S_ONE, S_ONE, S_ONE),
                1'b1, t_result'{32'h8000_0000, S_MAX});
        add_row(mk(0, 0, 9, 9, 0, 0, S_ONE, S_ONE, 0, S_ONE, S_ONE, S_ONE),
                1'b1, t_result'{32'h7fff_ffff, S_MAX});
        add_row(mk(V_ONE, 0, 0, 0, 0, 0, S_ONE, S_ONE, S_ONE, S_ONE, 0, S_ONE),
                1'b1, t_result'{32'h8000_0000, S_MAX});
        add_row(mk(0, 0, 0, 0, 0, 0, S_ONE, S_ONE, S_ONE, S_ONE, S_ONE, S_ONE),
                1'b1, t_result'{32'h0, S_MAX});
        add_row(mk(0, 0, 0, 0, 0, 1, S_ONE, S_ONE, S_ONE, S_ONE, S_ONE, S_ONE),
                1'b1, t_result'{32'h0001_0000, S_MAX});

        z_set[0] = S_MAX;
        z_set[1] = SPC_W'($urandom_range(32'h0100_0000, 32'h7fff_ffff));
        z_set[2] = SPC_W'($urandom_range(32'h0040_0000, 32'h0400_0000));
        z_set[3] = SPC_W'(1);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < n_early; i++)
            send_cell(cell_table[i].stim, cell_table[i].typed, cell_table[i].want);

        for (int p = 0; p < 4; p++) begin
            write_z_spacing(z_set[p]);
            for (int k = 0; k < PHASE_CELLS; k++)
                send_cell(rand_cell(p == 3), 1'b0, '0);
        end

        for (int i = n_early; i < cell_table.size(); i++)
            send_cell(cell_table[i].stim, cell_table[i].typed, cell_table[i].want);

        settle();
        repeat (400) @(posedge i_clk);
        if (div_queue.size() != 0)
            flag($sformatf("%0d divergence beats never arrived", div_queue.size()));
        if (fails == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
+incdir+hdl
hdl/sdm_pkg.sv
hdl/sdm_if.sv
hdl/sdm_mul.sv
hdl/sdm_div.sv
hdl/staggered_divergence_max_core.sv
test/tb.sv
